### hdl/rcz_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcz_pkg
// Shared types and constants of the 3x3 zero-padded RGB convolution.
// ----------------------------------------------------------------------------
package rcz_pkg;

    // default sizing of the top level
    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;
    localparam int DEF_FRAC_BITS  = 8;

    // pixel and arithmetic widths
    localparam int CH_W       = 8;
    localparam int PIX_W      = 3 * CH_W;
    localparam int TAP_W      = 16;
    localparam int PROD_W     = CH_W + 1 + TAP_W;
    localparam int CELL_SUM_W = PROD_W + 2;
    localparam int SUM_W      = PROD_W + 4;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int SIZE_W     = 12;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_COEF_TOP     = 3'd2,
        REG_COEF_MID     = 3'd3,
        REG_COEF_BOTTOM  = 3'd4
    } rcz_reg_idx_t;

    // operation codes of an input item
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // control handed to each column cell
    typedef struct packed {
        logic advance;
        logic shift;
        logic top_on;
        logic bot_on;
        logic col_on;
    } rcz_cell_ctrl_t;

endpackage

### hdl/rcz_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcz_cell
// One window column: holds three pixels, passes them on to its neighbour
// and forms the registered per-channel partial sum of its three taps.
// ----------------------------------------------------------------------------
module rcz_cell
    import rcz_pkg::*;
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  rcz_cell_ctrl_t                   ctrl,
    input  logic [2:0][PIX_W-1:0]            col_in,
    input  logic [2:0][TAP_W-1:0]            taps,
    output logic [2:0][PIX_W-1:0]            col_out,
    output logic [2:0][CELL_SUM_W-1:0]       psum
);

    logic [2:0][PIX_W-1:0]      col_reg;
    logic [2:0][CELL_SUM_W-1:0] psum_reg;
    logic [2:0][CELL_SUM_W-1:0] psum_next;
    logic [2:0]                 row_on;

    assign row_on = {ctrl.bot_on, 1'b1, ctrl.top_on};

    // three taps per channel, masked rows and column contribute nothing
    always_comb
    begin
        logic signed [PROD_W-1:0]     a;
        logic signed [PROD_W-1:0]     b;
        logic signed [PROD_W-1:0]     prod;
        logic signed [CELL_SUM_W-1:0] acc;
        for (int ch = 0; ch < 3; ch++)
        begin
            acc = '0;
            for (int r = 0; r < 3; r++)
            begin
                a    = PROD_W'($signed({1'b0, col_in[r][PIX_W-1-CH_W*ch -: CH_W]}));
                b    = PROD_W'($signed(taps[r]));
                prod = a * b;
                if (row_on[r] && ctrl.col_on)
                begin
                    acc = acc + CELL_SUM_W'(prod);
                end
            end
            psum_next[ch] = acc;
        end
    end

    // column moves one place on every transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
        end
        else if (ctrl.shift)
        begin
            col_reg <= col_in;
        end
    end

    // partial sums follow the pipeline
    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            psum_reg <= psum_next;
        end
    end

    assign col_out = col_reg;
    assign psum    = psum_reg;

endmodule

### hdl/rgb_conv3x3_zero_pad.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_conv3x3_zero_pad
// Streaming 3x3 convolution of RGB pixels with zero padding, two line stores
// and a chain of three column cells.
// ----------------------------------------------------------------------------
//  channel  | signals                                         | role
//  in       | in_valid, in_stall, operation, red/green/blue_in | pixel or flush
//  out      | out_valid, out_stall, red/green/blue_out, frame_end | filtered pixel
//  cfg      | cfg_we, cfg_index, cfg_data                     | register write
//
//  one item per cycle unless stalled; results pass stage one, cells, output reg
//  the first frame_width+1 items of a frame give no result
//  a stalled output freezes the whole pipeline and raises in_stall at once
//  reset clears counters, window and valid flags; line stores are not cleared
// ----------------------------------------------------------------------------
module rgb_conv3x3_zero_pad
    import rcz_pkg::*;
#(
    parameter int MAX_WIDTH      = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT     = DEF_MAX_HEIGHT,
    parameter int COEF_FRAC_BITS = DEF_FRAC_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  operation,
    input  logic [CH_W-1:0]       red_in,
    input  logic [CH_W-1:0]       green_in,
    input  logic [CH_W-1:0]       blue_in,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [CH_W-1:0]       red_out,
    output logic [CH_W-1:0]       green_out,
    output logic [CH_W-1:0]       blue_out,
    output logic                  frame_end,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int LW_W   = $clog2(MAX_WIDTH + 1);
    localparam int LH_W   = $clog2(MAX_HEIGHT + 1);
    localparam int IROW_W = $clog2(MAX_HEIGHT + 2);
    localparam int OROW_W = $clog2(MAX_HEIGHT + 1);

    // configuration registers
    logic [SIZE_W-1:0]     width_reg;
    logic [SIZE_W-1:0]     height_reg;
    logic [CFG_DATA_W-1:0] coef_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= SIZE_W'(2048);
            height_reg  <= SIZE_W'(2048);
            coef_reg[0] <= '0;
            coef_reg[1] <= CFG_DATA_W'(48'h000001000000);
            coef_reg[2] <= '0;
        end
        else if (cfg_we)
        begin
            unique case (rcz_reg_idx_t'(cfg_index))
                REG_FRAME_WIDTH:  width_reg   <= cfg_data[SIZE_W-1:0];
                REG_FRAME_HEIGHT: height_reg  <= cfg_data[SIZE_W-1:0];
                REG_COEF_TOP:     coef_reg[0] <= cfg_data;
                REG_COEF_MID:     coef_reg[1] <= cfg_data;
                REG_COEF_BOTTOM:  coef_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // frame sizes in effect
    logic [LW_W-1:0] live_w;
    logic [LH_W-1:0] live_h;

    always_comb
    begin
        if (width_reg == '0)
            live_w = LW_W'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            live_w = LW_W'(MAX_WIDTH);
        else
            live_w = LW_W'(width_reg);
        if (height_reg == '0)
            live_h = LH_W'(1);
        else if (32'(height_reg) > MAX_HEIGHT)
            live_h = LH_W'(MAX_HEIGHT);
        else
            live_h = LH_W'(height_reg);
    end

    // pipeline advance and input transfer
    logic out_valid_reg;
    logic en;
    logic in_xfer;

    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;
    assign in_xfer  = in_valid && en;

    // position counters
    logic [COL_W-1:0]  in_col_reg,  in_col_next;
    logic [IROW_W-1:0] in_row_reg,  in_row_next;
    logic [COL_W-1:0]  out_col_reg, out_col_next;
    logic [OROW_W-1:0] out_row_reg, out_row_next;
    logic              emit, last, row_wrap, out_wrap;

    always_comb
    begin
        emit     = (32'(in_row_reg) >= 32'd2)
                   || (in_row_reg == IROW_W'(1) && in_col_reg != '0);
        out_wrap = (32'(out_col_reg) + 32'd1) >= 32'(live_w);
        last     = emit && out_wrap && ((32'(out_row_reg) + 32'd1) >= 32'(live_h));
        row_wrap = (32'(in_col_reg) + 32'd1) >= 32'(live_w);

        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (emit)
        begin
            if (out_wrap)
            begin
                out_col_next = '0;
                if (32'(out_row_reg) < MAX_HEIGHT)
                    out_row_next = out_row_reg + OROW_W'(1);
            end
            else
            begin
                out_col_next = out_col_reg + COL_W'(1);
            end
        end

        in_col_next = in_col_reg + COL_W'(1);
        in_row_next = in_row_reg;
        if (row_wrap)
        begin
            in_col_next = '0;
            if (32'(in_row_reg) < MAX_HEIGHT + 1)
                in_row_next = in_row_reg + IROW_W'(1);
        end

        if (last)
        begin
            out_col_next = '0;
            out_row_next = '0;
            in_col_next  = '0;
            in_row_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else if (in_xfer)
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    // stage one: item held while the line stores answer
    logic             s1_valid_reg;
    logic             s1_emit_reg, s1_last_reg;
    logic             s1_top_reg, s1_bot_reg, s1_left_reg, s1_right_reg;
    logic [COL_W-1:0] s1_addr_reg;
    logic [PIX_W-1:0] s1_pix_reg;
    logic             fwd_reg;
    logic [PIX_W-1:0] fwd_a_reg, fwd_b_reg;
    logic [PIX_W-1:0] rd_a_reg, rd_b_reg;
    logic [PIX_W-1:0] above, two_above;
    logic [PIX_W-1:0] in_pix;

    assign in_pix = (operation == OP_FLUSH) ? '0 : {red_in, green_in, blue_in};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_xfer;
            fwd_reg      <= s1_valid_reg && (s1_addr_reg == in_col_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_emit_reg  <= emit;
            s1_last_reg  <= last;
            s1_top_reg   <= (out_row_reg != '0);
            s1_bot_reg   <= !((32'(out_row_reg) + 32'd1) >= 32'(live_h));
            s1_left_reg  <= (out_col_reg != '0);
            s1_right_reg <= (in_col_reg != '0);
            s1_addr_reg  <= in_col_reg;
            s1_pix_reg   <= in_pix;
            fwd_a_reg    <= s1_pix_reg;
            fwd_b_reg    <= above;
        end
    end

    // same column twice in a row: take the values just written
    assign above     = fwd_reg ? fwd_a_reg : rd_a_reg;
    assign two_above = fwd_reg ? fwd_b_reg : rd_b_reg;

    // line stores, read on transfer and written from stage one
    logic [PIX_W-1:0] mem_a [MAX_WIDTH];
    logic [PIX_W-1:0] mem_b [MAX_WIDTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rd_a_reg <= mem_a[in_col_reg];
            rd_b_reg <= mem_b[in_col_reg];
            if (s1_valid_reg)
            begin
                mem_a[s1_addr_reg] <= s1_pix_reg;
                mem_b[s1_addr_reg] <= above;
            end
        end
    end

    // chain of column cells: fresh column enters at the right
    logic [2:0][2:0][PIX_W-1:0]      cell_in;
    logic [2:0][2:0][PIX_W-1:0]      cell_out;
    logic [2:0][2:0][CELL_SUM_W-1:0] cell_sum;
    rcz_cell_ctrl_t                  cell_ctrl [3];

    assign cell_in[2] = {s1_pix_reg, above, two_above};
    assign cell_in[1] = cell_out[2];
    assign cell_in[0] = cell_out[1];

    for (genvar kc = 0; kc < 3; kc++)
    begin : g_cell
        logic [2:0][TAP_W-1:0] taps;

        for (genvar kr = 0; kr < 3; kr++)
        begin : g_tap
            assign taps[kr] = coef_reg[kr][(2-kc)*TAP_W +: TAP_W];
        end

        always_comb
        begin
            cell_ctrl[kc].advance = en;
            cell_ctrl[kc].shift   = en && s1_valid_reg;
            cell_ctrl[kc].top_on  = s1_top_reg;
            cell_ctrl[kc].bot_on  = s1_bot_reg;
            cell_ctrl[kc].col_on  = (kc == 0) ? s1_left_reg
                                  : (kc == 2) ? s1_right_reg : 1'b1;
        end

        rcz_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (cell_ctrl[kc]),
            .col_in  (cell_in[kc]),
            .taps    (taps),
            .col_out (cell_out[kc]),
            .psum    (cell_sum[kc])
        );
    end

    // stage two flags
    logic s2_valid_reg, s2_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s2_last_reg  <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= s1_valid_reg && s1_emit_reg;
            s2_last_reg  <= s1_last_reg;
        end
    end

    // final sum, scale and clamp per channel
    logic [2:0][CH_W-1:0] clamped;

    always_comb
    begin
        logic signed [SUM_W-1:0] sum;
        logic signed [SUM_W-1:0] shifted;
        for (int ch = 0; ch < 3; ch++)
        begin
            sum = SUM_W'($signed(cell_sum[0][ch])) + SUM_W'($signed(cell_sum[1][ch]))
                  + SUM_W'($signed(cell_sum[2][ch]));
            shifted = sum >>> COEF_FRAC_BITS;
            if (sum < 0)
                clamped[ch] = '0;
            else if (shifted > SUM_W'(255))
                clamped[ch] = CH_W'(255);
            else
                clamped[ch] = shifted[CH_W-1:0];
        end
    end

    // output register
    logic [2:0][CH_W-1:0] out_pix_reg;
    logic                 out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_pix_reg  <= clamped;
            out_last_reg <= s2_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign red_out   = out_pix_reg[0];
    assign green_out = out_pix_reg[1];
    assign blue_out  = out_pix_reg[2];
    assign frame_end = out_last_reg;

    // checks
    a_rise_from_s2: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s2_valid_reg))
        else $error("result appeared without a stage two item");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid_reg && out_stall))
        else $error("input stalled with an empty or moving output");

    a_fwd_col0: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && fwd_reg) |-> (s1_addr_reg == '0))
        else $error("line store bypass on a column other than the first");

endmodule
